FILE: hw/rtl/masked_pending_signal_queue_unit_defines.svh
// Assertion macros shared by the masked pending signal queue RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef MASKED_PENDING_SIGNAL_QUEUE_UNIT_DEFINES_SVH
`define MASKED_PENDING_SIGNAL_QUEUE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPSQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MPSQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/mpsq_pkg.sv
// Shared types, codes and constants of the masked pending signal queue.
// Used by every module of the block but mpsq_ram; depends on nothing else.
package mpsq_pkg;

   // Fixed field widths of the request and response transactions.
   localparam int OP_W    = 3;
   localparam int SIG_W   = 4;
   localparam int KIND_W  = 2;
   localparam int COUNT_W = 5;

   // Default sizes handed to the top level.
   localparam int DEFAULT_PENDING_DEPTH = 16;
   localparam int DEFAULT_SIGNAL_COUNT  = 16;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_RAISE         = 3'd0;
   localparam logic [OP_W-1:0] OP_DELIVER       = 3'd1;
   localparam logic [OP_W-1:0] OP_BLOCK_LOCAL   = 3'd2;
   localparam logic [OP_W-1:0] OP_UNBLOCK_LOCAL = 3'd3;
   localparam logic [OP_W-1:0] OP_BLOCK_GLOBAL  = 3'd4;
   localparam logic [OP_W-1:0] OP_UNBLOCK_GLOBAL = 3'd5;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NONE    = 2'd2;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACK,
      ST_DLV_FIRST,
      ST_DLV_SCAN,
      ST_DLV_END
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;     // latch the request transaction
      logic do_ack;     // apply a raise or mask operation and post its acknowledge
      logic rd_first;   // read the oldest list entry
      logic scan_step;  // consume the current entry and read the next one
      logic finish;     // post the final deliver result and commit the new fill
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_is_deliver;  // the offered request is a deliver
      logic out_free;        // the response register can take a result this cycle
      logic list_empty;      // no entries pending
      logic entry_blocked;   // the entry under the scan is masked
      logic scan_last;       // the entry under the scan is the newest one
      logic hold_valid;      // a delivered result waits for its successor
   } status_type;

endpackage

FILE: hw/rtl/mpsq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependencies.
module mpsq_ram #(
   parameter int  WIDTH = 4,
   parameter int  DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/mpsq_ctrl.sv
// Controller state machine of the masked pending signal queue.
// Depends on mpsq_pkg for the state type and the command and status structs.
module mpsq_ctrl
   import mpsq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  status_type status,
   output cmd_type    cmd,
   output logic       req_stall
);

   state_type state_ff;
   state_type state_in;
   logic      can_step;

   // A blocked entry never posts a result; a deliverable one may need the response register.
   assign can_step = status.entry_blocked || !status.hold_valid || status.out_free;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = status.req_is_deliver ? ST_DLV_FIRST : ST_ACK;
            end
         end
         ST_ACK: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_DLV_FIRST: begin
            state_in = status.list_empty ? ST_DLV_END : ST_DLV_SCAN;
         end
         ST_DLV_SCAN: begin
            if (can_step && status.scan_last) begin
               state_in = ST_DLV_END;
            end
         end
         ST_DLV_END: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_ACK: begin
            cmd.do_ack = status.out_free;
         end
         ST_DLV_FIRST: begin
            cmd.rd_first = !status.list_empty;
         end
         ST_DLV_SCAN: begin
            cmd.scan_step = can_step;
         end
         ST_DLV_END: begin
            cmd.finish = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

FILE: hw/rtl/mpsq_dpath.sv
// Datapath of the masked pending signal queue: masks, fill, scan pointers and response register.
// Depends on mpsq_pkg, mpsq_ram and the assertion macros header.
`include "masked_pending_signal_queue_unit_defines.svh"

module mpsq_dpath
   import mpsq_pkg::*;
#(
   parameter int PENDING_DEPTH = DEFAULT_PENDING_DEPTH,
   parameter int SIGNAL_COUNT  = DEFAULT_SIGNAL_COUNT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [SIG_W-1:0]    req_signal_id,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic [KIND_W-1:0]   rsp_result_kind,
   output logic [SIG_W-1:0]    rsp_delivered_id,
   output logic                rsp_dropped,
   output logic                rsp_last,
   output logic [COUNT_W-1:0]  rsp_pending_count,
   input  cmd_type             cmd,
   output status_type          status
);

   localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
   localparam int FW = $clog2(PENDING_DEPTH + 1);

   // Latched request.
   logic [OP_W-1:0]         op_ff, op_in;
   logic [SIG_W-1:0]        sig_ff, sig_in;
   // Architectural state.
   logic [SIGNAL_COUNT-1:0] local_mask_ff, local_mask_in;
   logic [SIGNAL_COUNT-1:0] global_mask_ff, global_mask_in;
   logic [FW-1:0]           fill_ff, fill_in;
   // Deliver scan state.
   logic [FW-1:0]           rd_ff, rd_in;
   logic [FW-1:0]           wr_ff, wr_in;
   logic [FW-1:0]           remain_ff, remain_in;
   logic                    hold_valid_ff, hold_valid_in;
   logic [SIG_W-1:0]        hold_id_ff, hold_id_in;
   logic [FW-1:0]           hold_count_ff, hold_count_in;
   // Response register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]       kind_ff, kind_in;
   logic [SIG_W-1:0]        id_ff, id_in;
   logic                    drop_ff, drop_in;
   logic                    last_ff, last_in;
   logic [FW-1:0]           count_ff, count_in;
   logic                    out_load;
   logic                    out_free;

   // Memory ports and helpers.
   logic                    ram_we;
   logic [AW-1:0]           ram_waddr;
   logic [SIG_W-1:0]        ram_wdata;
   logic                    ram_re;
   logic [AW-1:0]           ram_raddr;
   logic [SIG_W-1:0]        entry;
   logic [FW-1:0]           rd_plus;
   logic                    sig_ok;
   logic [SIGNAL_COUNT-1:0] sig_bit;
   logic                    entry_ok;
   logic                    entry_blocked;
   logic                    list_full;

   mpsq_ram #(
      .WIDTH (SIG_W),
      .DEPTH (PENDING_DEPTH)
   ) u_list (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (entry)
   );

   // Decode of the latched signal and of the entry under the scan.
   assign sig_ok    = 32'(sig_ff) < 32'(SIGNAL_COUNT);
   assign sig_bit   = sig_ok ? ({{(SIGNAL_COUNT-1){1'b0}}, 1'b1} << sig_ff) : '0;
   assign entry_ok  = 32'(entry) < 32'(SIGNAL_COUNT);
   assign entry_blocked = entry_ok &&
      (|((local_mask_ff | global_mask_ff) & ({{(SIGNAL_COUNT-1){1'b0}}, 1'b1} << entry)));
   assign list_full = fill_ff == FW'(PENDING_DEPTH);
   assign rd_plus   = rd_ff + FW'(1);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Read port: the oldest entry first, then one entry ahead of each scan step.
   assign ram_re    = cmd.rd_first || cmd.scan_step;
   assign ram_raddr = cmd.scan_step ? rd_plus[AW-1:0] : rd_ff[AW-1:0];

   // Status toward the controller.
   always_comb begin
      status.req_is_deliver = req_operation == OP_DELIVER;
      status.out_free       = out_free;
      status.list_empty     = fill_ff == '0;
      status.entry_blocked  = entry_blocked;
      status.scan_last      = rd_plus == fill_ff;
      status.hold_valid     = hold_valid_ff;
   end

   // Next-state logic of the datapath.
   always_comb begin
      op_in          = op_ff;
      sig_in         = sig_ff;
      local_mask_in  = local_mask_ff;
      global_mask_in = global_mask_ff;
      fill_in        = fill_ff;
      rd_in          = rd_ff;
      wr_in          = wr_ff;
      remain_in      = remain_ff;
      hold_valid_in  = hold_valid_ff;
      hold_id_in     = hold_id_ff;
      hold_count_in  = hold_count_ff;
      out_load       = 1'b0;
      kind_in        = KIND_ACK;
      id_in          = '0;
      drop_in        = 1'b0;
      last_in        = 1'b1;
      count_in       = fill_ff;
      ram_we         = 1'b0;
      ram_waddr      = wr_ff[AW-1:0];
      ram_wdata      = entry;

      // Latch a new request transaction and reset the scan.
      if (cmd.accept) begin
         op_in         = req_operation;
         sig_in        = req_signal_id;
         rd_in         = '0;
         wr_in         = '0;
         remain_in     = fill_ff;
         hold_valid_in = 1'b0;
      end

      // Raise and mask operations, acknowledged with the resulting fill.
      if (cmd.do_ack) begin
         out_load = 1'b1;
         case (op_ff)
            OP_RAISE: begin
               if (sig_ok) begin
                  if (list_full) begin
                     drop_in = 1'b1;
                  end else begin
                     ram_we    = 1'b1;
                     ram_waddr = fill_ff[AW-1:0];
                     ram_wdata = sig_ff;
                     fill_in   = fill_ff + FW'(1);
                  end
               end
            end
            OP_BLOCK_LOCAL:    local_mask_in  = local_mask_ff | sig_bit;
            OP_UNBLOCK_LOCAL:  local_mask_in  = local_mask_ff & ~sig_bit;
            OP_BLOCK_GLOBAL:   global_mask_in = global_mask_ff | sig_bit;
            OP_UNBLOCK_GLOBAL: global_mask_in = global_mask_ff & ~sig_bit;
            default: begin
               drop_in = 1'b0;
            end
         endcase
         count_in = fill_in;
      end

      // One scan step: compact a blocked entry, or hold a deliverable one and
      // post the previously held result, which is now known not to be the last.
      if (cmd.scan_step) begin
         rd_in = rd_plus;
         if (entry_blocked) begin
            ram_we    = 1'b1;
            ram_waddr = wr_ff[AW-1:0];
            ram_wdata = entry;
            wr_in     = wr_ff + FW'(1);
         end else begin
            remain_in     = remain_ff - FW'(1);
            hold_valid_in = 1'b1;
            hold_id_in    = entry;
            hold_count_in = remain_ff - FW'(1);
            if (hold_valid_ff) begin
               out_load = 1'b1;
               kind_in  = KIND_DELIVER;
               id_in    = hold_id_ff;
               last_in  = 1'b0;
               count_in = hold_count_ff;
            end
         end
      end

      // End of a deliver: post the held result as the last one, or report none.
      if (cmd.finish) begin
         fill_in       = wr_ff;
         out_load      = 1'b1;
         hold_valid_in = 1'b0;
         if (hold_valid_ff) begin
            kind_in  = KIND_DELIVER;
            id_in    = hold_id_ff;
            count_in = hold_count_ff;
         end else begin
            kind_in  = KIND_NONE;
            count_in = wr_ff;
         end
      end

      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         local_mask_ff  <= '0;
         global_mask_ff <= '0;
         fill_ff        <= '0;
         hold_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         local_mask_ff  <= local_mask_in;
         global_mask_ff <= global_mask_in;
         fill_ff        <= fill_in;
         hold_valid_ff  <= hold_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      sig_ff        <= sig_in;
      rd_ff         <= rd_in;
      wr_ff         <= wr_in;
      remain_ff     <= remain_in;
      hold_id_ff    <= hold_id_in;
      hold_count_ff <= hold_count_in;
      if (out_load) begin
         kind_ff  <= kind_in;
         id_ff    <= id_in;
         drop_ff  <= drop_in;
         last_ff  <= last_in;
         count_ff <= count_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = kind_ff;
   assign rsp_delivered_id  = id_ff;
   assign rsp_dropped       = drop_ff;
   assign rsp_last          = last_ff;
   assign rsp_pending_count = COUNT_W'(count_ff);

   // The fill never passes the list depth.
   `MPSQ_ASSERT_IMPLY(a_fill_range, clock, reset, 1'b1, fill_ff <= FW'(PENDING_DEPTH), "fill exceeds depth")
   // Compaction never writes ahead of the entry being read.
   `MPSQ_ASSERT_IMPLY(a_compact_order, clock, reset, cmd.scan_step, wr_ff <= rd_ff, "compaction overtook the scan")
   // A result is only loaded when the response register can take it.
   `MPSQ_ASSERT_IMPLY(a_load_free, clock, reset, out_load, !rsp_valid_ff || !rsp_stall, "response overwritten while stalled")
   // After a deliver finishes the held result is gone and the scan is over.
   `MPSQ_ASSERT_NEXT(a_finish_clear, clock, reset, cmd.finish, !hold_valid_ff && rsp_valid_ff && last_ff, "deliver did not close")

endmodule

FILE: hw/rtl/masked_pending_signal_queue_unit.sv
// Masked pending signal queue: an ordered list of pending signal numbers with a
// local and a global block mask. A raise appends an in-range signal (dropped and
// flagged when the list is full), block and unblock set or clear one mask bit, and a
// deliver emits every unmasked entry oldest first, compacting the masked ones to the
// front in order; a deliver that finds nothing emits one "none" result. One request
// transaction is worked at a time. A raise or mask operation is latched on acceptance
// and presents its single result once the result side can take it; the next request
// is accepted after the controller returns to idle. A deliver walks the list through
// the single read port of the list memory, one entry per cycle while the result side
// does not stall, from acceptance through the first read, the scan and the end state
// back to idle; each result of a deliver is posted once the next unmasked entry is
// found or the scan ends, as the last flag is only known once the following entries
// are scanned. The list memory needs no clearing after reset: only entries below the
// fill are ever used. Depends on mpsq_pkg, mpsq_ctrl and mpsq_dpath.
module masked_pending_signal_queue_unit
   import mpsq_pkg::*;
#(
   parameter int PENDING_DEPTH = DEFAULT_PENDING_DEPTH,
   parameter int SIGNAL_COUNT  = DEFAULT_SIGNAL_COUNT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [OP_W-1:0]    req_operation,
   input  logic [SIG_W-1:0]   req_signal_id,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [KIND_W-1:0]  rsp_result_kind,
   output logic [SIG_W-1:0]   rsp_delivered_id,
   output logic               rsp_dropped,
   output logic               rsp_last,
   output logic [COUNT_W-1:0] rsp_pending_count
);

   cmd_type    cmd;
   status_type status;

   // Sequencer of the request transactions.
   mpsq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   // List, masks and response register.
   mpsq_dpath #(
      .PENDING_DEPTH (PENDING_DEPTH),
      .SIGNAL_COUNT  (SIGNAL_COUNT)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_operation     (req_operation),
      .req_signal_id     (req_signal_id),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_delivered_id  (rsp_delivered_id),
      .rsp_dropped       (rsp_dropped),
      .rsp_last          (rsp_last),
      .rsp_pending_count (rsp_pending_count),
      .cmd               (cmd),
      .status            (status)
   );

endmodule
